// ===== hw/rtl/rhc_pkg.sv =====
// shared types and constants for the rgb to hsv converter
// used by every module of the block, no dependencies

package rhc_pkg;

    localparam int CH_W  = 8;
    localparam int HUE_W = 15;
    localparam int HQ_W  = 12;
    localparam int HN_W  = 20;
    localparam int SN_W  = 16;
    localparam int SQ_W  = 8;

    localparam logic [HUE_W-1:0] HUE_SECTOR = HUE_W'(3840);
    localparam logic [HUE_W-1:0] BASE_GREEN = HUE_W'(7680);
    localparam logic [HUE_W-1:0] BASE_BLUE  = HUE_W'(15360);
    localparam logic [HUE_W:0]   HUE_TURN   = (HUE_W+1)'(23040);

    typedef enum logic [1:0] {
        SEC_RED   = 2'd0,
        SEC_GREEN = 2'd1,
        SEC_BLUE  = 2'd2
    } t_sector;

    typedef struct packed {
        logic [CH_W-1:0] bright;
        logic [CH_W-1:0] delta;
        logic [CH_W-1:0] mag;
        logic            neg;
        t_sector         sector;
        logic [CH_W-1:0] alpha;
    } t_minmax;

    typedef struct packed {
        logic [HN_W-1:0] hue_rem;
        logic [HQ_W-1:0] hue_q;
        logic [CH_W-1:0] hue_div;
        logic [SN_W-1:0] sat_rem;
        logic [SQ_W-1:0] sat_q;
        t_sector         sector;
        logic            neg;
        logic            gray;
        logic [CH_W-1:0] bright;
        logic [CH_W-1:0] alpha;
    } t_work;

endpackage

// ===== hw/rtl/rhc_front.sv =====
// front of the pipe: max, min, sector select, then dividends
// two register stages, depends on rhc_pkg

module rhc_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic [7:0]       i_red,
    input  logic [7:0]       i_green,
    input  logic [7:0]       i_blue,
    input  logic [7:0]       i_alpha_in,
    output logic             o_valid,
    input  logic             i_stall,
    output rhc_pkg::t_work   o_work
);
    import rhc_pkg::*;

    t_minmax         n_a, r_a;
    t_work           n_b, r_b;
    logic            r_va, r_vb;
    logic            stall_a, stall_b;
    logic [CH_W-1:0] mx, mn, plus, minus;

    assign stall_b = r_vb & i_stall;
    assign stall_a = r_va & stall_b;
    assign o_stall = stall_a;
    assign o_valid = r_vb;
    assign o_work  = r_b;

    always_comb begin
        mx = i_red;
        if (i_green > mx) mx = i_green;
        if (i_blue > mx) mx = i_blue;
        mn = i_red;
        if (i_green < mn) mn = i_green;
        if (i_blue < mn) mn = i_blue;
        if (i_red == mx) begin
            n_a.sector = SEC_RED;
            plus  = i_green;
            minus = i_blue;
        end else if (i_green == mx) begin
            n_a.sector = SEC_GREEN;
            plus  = i_blue;
            minus = i_red;
        end else begin
            n_a.sector = SEC_BLUE;
            plus  = i_red;
            minus = i_green;
        end
        n_a.bright = mx;
        n_a.delta  = mx - mn;
        n_a.neg    = plus < minus;
        n_a.mag    = n_a.neg ? (minus - plus) : (plus - minus);
        n_a.alpha  = i_alpha_in;
    end

    // negative offsets need ceiling, so bias the dividend by delta - 1
    always_comb begin
        n_b.hue_rem = (HN_W'(r_a.mag) << 12) - (HN_W'(r_a.mag) << 8)
                    + (r_a.neg ? HN_W'(r_a.delta - 8'd1) : '0);
        n_b.hue_q   = '0;
        n_b.hue_div = r_a.delta;
        n_b.sat_rem = (SN_W'(r_a.delta) << 8) - SN_W'(r_a.delta);
        n_b.sat_q   = '0;
        n_b.sector  = r_a.sector;
        n_b.neg     = r_a.neg;
        n_b.gray    = r_a.delta == '0;
        n_b.bright  = r_a.bright;
        n_b.alpha   = r_a.alpha;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
        end else begin
            if (!stall_a) r_va <= i_valid;
            if (!stall_b) r_vb <= r_va;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!stall_a) r_a <= n_a;
        if (!stall_b) r_b <= n_b;
    end

endmodule

// ===== hw/rtl/rhc_div_stage.sv =====
// one restoring-division bit of hue, and of saturation if K < 8
// one register stage, depends on rhc_pkg

module rhc_div_stage #(
    parameter int K = 0
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  rhc_pkg::t_work   i_work,
    output logic             o_valid,
    input  logic             i_stall,
    output rhc_pkg::t_work   o_work
);
    import rhc_pkg::*;

    t_work           n_work, r_work;
    logic            r_valid;
    logic [HN_W-1:0] hue_sh;
    logic            hue_ge;

    assign o_stall = r_valid & i_stall;
    assign o_valid = r_valid;
    assign o_work  = r_work;
    assign hue_sh  = HN_W'(i_work.hue_div) << K;
    assign hue_ge  = i_work.hue_rem >= hue_sh;

    generate
        if (K < SQ_W) begin : g_sat
            logic [SN_W-1:0] sat_sh;
            logic            sat_ge;
            assign sat_sh = SN_W'(i_work.bright) << K;
            assign sat_ge = i_work.sat_rem >= sat_sh;
            always_comb begin
                n_work            = i_work;
                n_work.hue_q[K]   = hue_ge;
                n_work.hue_rem    = hue_ge ? (i_work.hue_rem - hue_sh) : i_work.hue_rem;
                n_work.sat_q[K]   = sat_ge;
                n_work.sat_rem    = sat_ge ? (i_work.sat_rem - sat_sh) : i_work.sat_rem;
            end
        end else begin : g_hue_only
            always_comb begin
                n_work            = i_work;
                n_work.hue_q[K]   = hue_ge;
                n_work.hue_rem    = hue_ge ? (i_work.hue_rem - hue_sh) : i_work.hue_rem;
            end
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall) r_work <= n_work;
    end

endmodule

// ===== hw/rtl/rhc_back.sv =====
// sector offset, wrap and special cases, then the output register
// one register stage, depends on rhc_pkg

module rhc_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  rhc_pkg::t_work   i_work,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [14:0]      o_hue,
    output logic [7:0]       o_saturation,
    output logic [7:0]       o_brightness,
    output logic [7:0]       o_alpha_out
);
    import rhc_pkg::*;

    logic             r_valid;
    logic [HUE_W-1:0] r_hue, n_hue;
    logic [SQ_W-1:0]  r_sat, n_sat;
    logic [CH_W-1:0]  r_bright, r_alpha;
    logic [HUE_W-1:0] base, qx;
    logic [HUE_W:0]   wrapped;

    assign o_stall      = r_valid & i_stall;
    assign o_valid      = r_valid;
    assign o_hue        = r_hue;
    assign o_saturation = r_sat;
    assign o_brightness = r_bright;
    assign o_alpha_out  = r_alpha;

    always_comb begin
        case (i_work.sector)
            SEC_RED:   base = '0;
            SEC_GREEN: base = BASE_GREEN;
            SEC_BLUE:  base = BASE_BLUE;
            default:   base = '0;
        endcase
        qx      = HUE_W'(i_work.hue_q);
        wrapped = {1'b0, base} + HUE_TURN - {1'b0, qx};
        if (i_work.gray) begin
            n_hue = '0;
        end else if (!i_work.neg) begin
            n_hue = base + qx;
        end else if (qx > base) begin
            n_hue = wrapped[HUE_W-1:0];
        end else begin
            n_hue = base - qx;
        end
        n_sat = (i_work.bright == '0) ? '0 : i_work.sat_q;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall) begin
            r_hue    <= n_hue;
            r_sat    <= n_sat;
            r_bright <= i_work.bright;
            r_alpha  <= i_work.alpha;
        end
    end

endmodule

// ===== hw/rtl/rgb_to_hsv_converter_core.sv =====
// top level of the rgb to hsv converter
// depends on rhc_pkg, rhc_front, rhc_div_stage and rhc_back
//
// input channel: i_valid / o_stall with i_red, i_green, i_blue, i_alpha_in;
// an item is taken at a clock edge with i_valid high and o_stall low.
// output channel: o_valid / i_stall with o_hue (1/64 degree), o_saturation,
// o_brightness and o_alpha_out; an item leaves with o_valid high, i_stall low.
// the pipe is two front stages (max/min, dividends), twelve divider stages
// with one hue quotient bit each (the last eight also take one saturation
// bit), and the output register. throughput is one item per cycle while
// i_stall is low; the twelve-bit hue quotient sets the depth.
// each stage holds while the one after it is full and stalled, so a stall
// at the output fills empty slots first and reaches o_stall only when the
// stages in front are all occupied; nothing is dropped or repeated.
// synchronous active-low reset empties every stage; payload is not cleared.
// no state is kept between items.

module rgb_to_hsv_converter_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_red,
    input  logic [7:0]  i_green,
    input  logic [7:0]  i_blue,
    input  logic [7:0]  i_alpha_in,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [14:0] o_hue,
    output logic [7:0]  o_saturation,
    output logic [7:0]  o_brightness,
    output logic [7:0]  o_alpha_out
);
    import rhc_pkg::*;

    t_work work [HQ_W+1];
    logic  vld  [HQ_W+1];
    logic  stl  [HQ_W+1];

    rhc_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_red      (i_red),
        .i_green    (i_green),
        .i_blue     (i_blue),
        .i_alpha_in (i_alpha_in),
        .o_valid    (vld[0]),
        .i_stall    (stl[0]),
        .o_work     (work[0])
    );

    generate
        for (genvar s = 0; s < HQ_W; s++) begin : g_div
            rhc_div_stage #(
                .K (HQ_W - 1 - s)
            ) u_stage (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_valid (vld[s]),
                .o_stall (stl[s]),
                .i_work  (work[s]),
                .o_valid (vld[s+1]),
                .i_stall (stl[s+1]),
                .o_work  (work[s+1])
            );
        end
    endgenerate

    rhc_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (vld[HQ_W]),
        .o_stall      (stl[HQ_W]),
        .i_work       (work[HQ_W]),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_hue        (o_hue),
        .o_saturation (o_saturation),
        .o_brightness (o_brightness),
        .o_alpha_out  (o_alpha_out)
    );

`ifndef SYNTHESIS
    a_hue_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_hue < 15'd23040)
        else $error("hue out of range");

    a_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_brightness == 8'd0 |-> o_saturation == 8'd0 && o_hue == 15'd0)
        else $error("black pixel with nonzero hue or saturation");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("pipe not empty after reset");

    a_stall_chain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> i_stall && o_valid)
        else $error("input stalled while output drains");
`endif

endmodule
